// File: sv/bto_pkg.sv
// shared types and constants of the binary trie order-statistic block
// no dependencies; used by the top level and the testbench
package bto_pkg;

    localparam int KEY_W    = 30;
    localparam int RANK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ANSWERED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED  = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  key_value;
        logic [RANK_W-1:0] rank;
    } cmd_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    found_value;
    } res_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_STEP,
        ST_INS_WAIT,
        ST_QRY_STEP,
        ST_QRY_CNT,
        ST_QRY_LNK,
        ST_FINISH
    } state_t;

endpackage

// File: sv/bto_stream.sv
// valid/ready stream carrying one word per handshake
// word type is set per instance; no other dependencies
interface bto_stream #(
    parameter type word_t = logic
) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/bto_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module bto_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/binary_trie_order_statistic.sv
// binary trie order-statistic multiset: insert keys, ask for the k-th smallest
// depends on bto_pkg, bto_stream and bto_ram
//
// usage
//   request carries one command word: cmd 0 inserts key_value, cmd 1 asks for
//   the rank-th smallest stored key (one-based). response carries one word per
//   command: status and, for an answered query, found_value.
//   one command is worked on at a time; request.ready is high only while the
//   block is idle. a finished word sits in the output register until taken,
//   and the next command is accepted while it waits there.
// walk
//   the walk descends VALUE_BITS levels through the node rams, each level one
//   dependent registered read of the links and counts rams.
//   insert: a level that allocates a new node writes its count of one; an existing
//   node is read first, then its count is written back one higher.
//   query: read the left child's count and links; going right reads the right child's links.
//   refused inserts and out-of-range ranks go straight to the finish state.
// reset
//   rst_n at once clears the stored total, the root links and the output valid
//   and sets the free pointer to one. node entries are written when allocated, so ram
//   contents need no clearing pass and the block is ready right after reset.
//   a stalled response holds its word and blocks only the finish of the next.
module binary_trie_order_statistic #(
    parameter int VALUE_BITS = 30,
    parameter int NODE_COUNT = 65536
) (
    input  logic      clk,
    input  logic      rst_n,
    bto_stream.sink   request,
    bto_stream.source response
);

    localparam int NODE_BITS = $clog2(NODE_COUNT);
    localparam int FREE_W    = NODE_BITS + 1;
    localparam int LINK_W    = 2 * NODE_BITS;
    localparam int LVL_W     = $clog2(VALUE_BITS + 1);
    localparam int KEY_W     = bto_pkg::KEY_W;
    localparam int COUNT_W   = bto_pkg::COUNT_W;
    localparam int RANK_W    = bto_pkg::RANK_W;
    localparam int STATUS_W  = bto_pkg::STATUS_W;

    // highest free pointer that still leaves room for a full path
    localparam logic [FREE_W-1:0] FREE_LIMIT = FREE_W'(NODE_COUNT - VALUE_BITS);
    localparam logic [LVL_W-1:0]  LVL_TOP    = LVL_W'(VALUE_BITS - 1);

    // control state
    bto_pkg::state_t       state_reg, state_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [COUNT_W-1:0]    total_reg, total_next;
    logic [LINK_W-1:0]     root_reg, root_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic                  fresh_reg, fresh_next;

    // walk payload
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [NODE_BITS-1:0]  cur_reg, cur_next;
    logic [LINK_W-1:0]     links_reg, links_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [KEY_W-1:0]      out_found_reg, out_found_next;

    // ram ports
    logic                  lnk_we, cnt_we, ram_re;
    logic [NODE_BITS-1:0]  lnk_waddr, cnt_waddr, ram_raddr;
    logic [LINK_W-1:0]     lnk_wdata, lnk_rdata;
    logic [COUNT_W-1:0]    cnt_wdata, cnt_rdata;

    // decisions shared by the state and datapath logic
    logic                  in_fire;
    logic                  ins_refuse;
    logic                  qry_range;
    logic                  last_lvl;
    logic                  key_bit;
    logic [NODE_BITS-1:0]  ins_child;
    logic                  ins_alloc;
    logic [NODE_BITS-1:0]  new_node;
    logic [LINK_W-1:0]     links_linked;
    logic [NODE_BITS-1:0]  left_child;
    logic [NODE_BITS-1:0]  right_child;
    logic                  left_none;
    logic                  go_left;
    logic                  out_free;
    logic [VALUE_BITS-1:0] lvl_mask;
    logic [KEY_W+VALUE_BITS-1:0] key_wide;
    logic [KEY_W+VALUE_BITS-1:0] val_wide;

    // child link 0 in the low half, child link 1 in the high half
    bto_ram #(.WIDTH(LINK_W), .DEPTH(NODE_COUNT)) u_links (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (lnk_rdata)
    );

    bto_ram #(.WIDTH(COUNT_W), .DEPTH(NODE_COUNT)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (cnt_rdata)
    );

    assign in_fire    = request.valid && request.ready;
    assign ins_refuse = (free_reg > FREE_LIMIT) || (total_reg == {COUNT_W{1'b1}});
    assign qry_range  = (request.data.rank == '0) || (request.data.rank > total_reg);
    assign last_lvl   = (lvl_reg == '0);

    // insert: pick the child on the key bit; below a fresh node all links are empty
    assign key_bit     = key_reg[lvl_reg];
    assign ins_child   = key_bit ? links_reg[LINK_W-1:NODE_BITS] : links_reg[NODE_BITS-1:0];
    assign ins_alloc   = fresh_reg || (ins_child == '0);
    assign new_node    = free_reg[NODE_BITS-1:0];
    assign links_linked = key_bit ? {new_node, links_reg[NODE_BITS-1:0]}
                                  : {links_reg[LINK_W-1:NODE_BITS], new_node};

    // query: left subtree count decides the direction
    assign left_child  = links_reg[NODE_BITS-1:0];
    assign right_child = links_reg[LINK_W-1:NODE_BITS];
    assign left_none   = (left_child == '0);
    assign go_left     = (rank_reg <= cnt_rdata);

    assign out_free = !out_valid_reg || response.ready;
    assign lvl_mask = VALUE_BITS'(1) << lvl_reg;

    // key bits above the field width read as zero, result bits above it drop
    assign key_wide = {{VALUE_BITS{1'b0}}, request.data.key_value};
    assign val_wide = {{KEY_W{1'b0}}, val_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bto_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (request.data.cmd == bto_pkg::CMD_INSERT)
                    begin
                        state_next = ins_refuse ? bto_pkg::ST_FINISH : bto_pkg::ST_INS_STEP;
                    end
                    else
                    begin
                        state_next = qry_range ? bto_pkg::ST_FINISH : bto_pkg::ST_QRY_STEP;
                    end
                end
            end
            bto_pkg::ST_INS_STEP:
            begin
                if (!ins_alloc)
                begin
                    state_next = bto_pkg::ST_INS_WAIT;
                end
                else if (last_lvl)
                begin
                    state_next = bto_pkg::ST_FINISH;
                end
            end
            bto_pkg::ST_INS_WAIT:
            begin
                state_next = last_lvl ? bto_pkg::ST_FINISH : bto_pkg::ST_INS_STEP;
            end
            bto_pkg::ST_QRY_STEP:
            begin
                if (!left_none)
                begin
                    state_next = bto_pkg::ST_QRY_CNT;
                end
                else
                begin
                    state_next = last_lvl ? bto_pkg::ST_FINISH : bto_pkg::ST_QRY_LNK;
                end
            end
            bto_pkg::ST_QRY_CNT:
            begin
                if (last_lvl)
                begin
                    state_next = bto_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = go_left ? bto_pkg::ST_QRY_STEP : bto_pkg::ST_QRY_LNK;
                end
            end
            bto_pkg::ST_QRY_LNK:
            begin
                state_next = bto_pkg::ST_QRY_STEP;
            end
            bto_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = bto_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bto_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, ram controls and output register
    always_comb
    begin
        free_next       = free_reg;
        total_next      = total_reg;
        root_next       = root_reg;
        lvl_next        = lvl_reg;
        fresh_next      = fresh_reg;
        key_next        = key_reg;
        rank_next       = rank_reg;
        val_next        = val_reg;
        cur_next        = cur_reg;
        links_next      = links_reg;
        res_status_next = res_status_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_valid_next  = out_valid_reg && !response.ready;

        lnk_we    = 1'b0;
        lnk_waddr = cur_reg;
        lnk_wdata = links_linked;
        cnt_we    = 1'b0;
        cnt_waddr = new_node;
        cnt_wdata = COUNT_W'(1);
        ram_re    = 1'b0;
        ram_raddr = ins_child;

        case (state_reg)
            bto_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    key_next   = key_wide[VALUE_BITS-1:0];
                    rank_next  = request.data.rank;
                    val_next   = '0;
                    lvl_next   = LVL_TOP;
                    cur_next   = '0;
                    links_next = root_reg;
                    fresh_next = 1'b0;
                    if (request.data.cmd == bto_pkg::CMD_INSERT)
                    begin
                        res_status_next = ins_refuse ? bto_pkg::STATUS_REFUSED
                                                     : bto_pkg::STATUS_INSERTED;
                    end
                    else
                    begin
                        res_status_next = qry_range ? bto_pkg::STATUS_RANGE
                                                    : bto_pkg::STATUS_ANSWERED;
                    end
                end
            end
            bto_pkg::ST_INS_STEP:
            begin
                if (ins_alloc)
                begin
                    // link the new node into its parent, the root lives in flops
                    if (cur_reg == '0)
                    begin
                        root_next = links_linked;
                    end
                    else
                    begin
                        lnk_we = 1'b1;
                    end
                    cnt_we     = 1'b1;
                    free_next  = free_reg + FREE_W'(1);
                    cur_next   = new_node;
                    links_next = '0;
                    fresh_next = 1'b1;
                    lvl_next   = lvl_reg - LVL_W'(1);
                    if (last_lvl)
                    begin
                        total_next = total_reg + COUNT_W'(1);
                    end
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ins_child;
                    cur_next  = ins_child;
                end
            end
            bto_pkg::ST_INS_WAIT:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = cur_reg;
                cnt_wdata  = cnt_rdata + COUNT_W'(1);
                links_next = lnk_rdata;
                lvl_next   = lvl_reg - LVL_W'(1);
                if (last_lvl)
                begin
                    total_next = total_reg + COUNT_W'(1);
                end
            end
            bto_pkg::ST_QRY_STEP:
            begin
                if (!left_none)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = left_child;
                end
                else
                begin
                    // empty left subtree: go right without reading a count
                    val_next = val_reg | lvl_mask;
                    if (!last_lvl)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = right_child;
                    end
                end
            end
            bto_pkg::ST_QRY_CNT:
            begin
                if (go_left)
                begin
                    links_next = lnk_rdata;
                    lvl_next   = lvl_reg - LVL_W'(1);
                end
                else
                begin
                    rank_next = rank_reg - cnt_rdata;
                    val_next  = val_reg | lvl_mask;
                    if (!last_lvl)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = right_child;
                    end
                end
            end
            bto_pkg::ST_QRY_LNK:
            begin
                links_next = lnk_rdata;
                lvl_next   = lvl_reg - LVL_W'(1);
            end
            bto_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = (res_status_reg == bto_pkg::STATUS_ANSWERED)
                                      ? val_wide[KEY_W-1:0] : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bto_pkg::ST_IDLE;
            free_reg      <= FREE_W'(1);
            total_reg     <= '0;
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            fresh_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            total_reg     <= total_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        rank_reg       <= rank_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        links_reg      <= links_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
    end

    assign request.ready             = (state_reg == bto_pkg::ST_IDLE);
    assign response.valid            = out_valid_reg;
    assign response.data.status      = out_status_reg;
    assign response.data.found_value = out_found_reg;

endmodule

// File: tb/tb_binary_trie_order_statistic.sv
`timescale 1ns / 1ps
// testbench for binary_trie_order_statistic: inserts and k-th smallest queries
// depends on bto_pkg, bto_stream and the top level; checks every response word
// against a trie kept inside this file
module tb_binary_trie_order_statistic;

    localparam int VALUE_BITS  = 30;
    localparam int NODE_COUNT  = 65536;
    localparam int NODE_BITS   = $clog2(NODE_COUNT);
    localparam int KEY_W       = bto_pkg::KEY_W;
    localparam int RANK_W      = bto_pkg::RANK_W;
    // long receiver hold-off, well under the watchdog limit
    localparam int HOLD_CYCLES = 600;
    // cycles with no word accepted on either side before the run is called dead
    localparam int STALL_LIMIT = 5000;
    // drain wait at the end, a little above the slowest walk
    localparam int DRAIN_CYCLES = 150;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;

    bto_stream #(.word_t(bto_pkg::cmd_word_t)) req_ch ();
    bto_stream #(.word_t(bto_pkg::res_word_t)) rsp_ch ();

    binary_trie_order_statistic #(
        .VALUE_BITS(VALUE_BITS),
        .NODE_COUNT(NODE_COUNT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .response(rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow trie: node 0 is the root, a link of 0 means no child
    // ------------------------------------------------------------------
    bit [NODE_BITS-1:0] trie_link  [NODE_COUNT][2];
    bit [31:0]          trie_count [NODE_COUNT];
    int                 free_node    = 1;
    bit [31:0]          stored_total = 0;

    bto_pkg::res_word_t pending_answers [$];
    int                 fail_count = 0;

    // sender burst state
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // bumped by the stimulus to ask the receiver for one long hold-off
    int hold_asked = 0;

    // apply one command word to the shadow trie, return the response word
    function automatic bto_pkg::res_word_t multiset_apply(input bto_pkg::cmd_word_t w);
        bto_pkg::res_word_t r;
        bit [NODE_BITS-1:0] node;
        bit [NODE_BITS-1:0] nxt;
        bit [31:0]          k;
        bit [31:0]          left_cnt;
        bit                 b;
        r.status      = bto_pkg::STATUS_INSERTED;
        r.found_value = '0;
        if (w.cmd == bto_pkg::CMD_INSERT)
        begin
            // refused when the pool cannot hold a full path or the total is saturated
            if (NODE_COUNT - free_node < VALUE_BITS || stored_total == 32'hFFFF_FFFF)
            begin
                r.status = bto_pkg::STATUS_REFUSED;
            end
            else
            begin
                node = '0;
                for (int lvl = VALUE_BITS - 1; lvl >= 0; lvl--)
                begin
                    b   = w.key_value[lvl];
                    nxt = trie_link[node][b];
                    if (nxt == '0)
                    begin
                        nxt = NODE_BITS'(free_node);
                        free_node++;
                        trie_link[node][b] = nxt;
                    end
                    node = nxt;
                    trie_count[node]++;
                end
                stored_total++;
            end
        end
        else if (w.rank == 0 || w.rank > stored_total)
        begin
            r.status = bto_pkg::STATUS_RANGE;
        end
        else
        begin
            // descend: left while k fits in the left subtree, else skip it and set the bit
            r.status = bto_pkg::STATUS_ANSWERED;
            k    = w.rank;
            node = '0;
            for (int lvl = VALUE_BITS - 1; lvl >= 0; lvl--)
            begin
                nxt      = trie_link[node][0];
                left_cnt = (nxt != '0) ? trie_count[nxt] : 32'd0;
                if (k <= left_cnt)
                begin
                    node = nxt;
                end
                else
                begin
                    k                  = k - left_cnt;
                    r.found_value[lvl] = 1'b1;
                    node               = trie_link[node][1];
                end
            end
        end
        return r;
    endfunction

    // predict on every accepted command word
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && req_ch.valid && req_ch.ready)
            pending_answers.push_back(multiset_apply(req_ch.data));
    end

    // compare every accepted response word with the oldest prediction
    always @(posedge clk)
    begin
        bto_pkg::res_word_t want;
        if (rst_n === 1'b1 && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("response word with nothing expected: status %0d found_value %0d",
                       rsp_ch.data.status, rsp_ch.data.found_value);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.data.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp_ch.data.status);
                    fail_count++;
                end
                if (rsp_ch.data.found_value !== want.found_value)
                begin
                    $error("found_value mismatch: expected %0d, actual %0d",
                           want.found_value, rsp_ch.data.found_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: no word moving on either side for too long ends the run
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: switches between stall patterns, plus a long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int hold_taken;
        int cyc;
        rsp_ch.ready = 1'b0;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        hold_taken = 0;
        cyc        = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_asked != hold_taken)
            begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;                      // no stalls
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));  // coin flip
                    2:       rsp_ch.ready <= ($urandom_range(0, 4) != 0);
                    default: rsp_ch.ready <= (cyc % 3 != 0);            // fixed rhythm
                endcase
            end
        end
    end

    // send one command word; gaps fall between bursts when enabled
    task automatic send_word(input bto_pkg::cmd_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_insert(input logic [KEY_W-1:0] key);
        bto_pkg::cmd_word_t w;
        w.cmd       = bto_pkg::CMD_INSERT;
        w.key_value = key;
        w.rank      = $urandom();   // ignored by an insert
        send_word(w);
    endtask

    task automatic send_query(input logic [RANK_W-1:0] k);
        bto_pkg::cmd_word_t w;
        w.cmd       = bto_pkg::CMD_QUERY;
        w.key_value = KEY_W'($urandom());   // ignored by a query
        w.rank      = k;
        send_word(w);
    endtask

    // stop offering the last word, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // extremes: empty set, smallest and largest keys, duplicates, rank bounds
    task automatic test_directed_edges();
        bto_pkg::cmd_word_t w;
        send_query(32'd0);              // rank zero on empty set
        send_query(32'd1);              // any rank is out of range while empty
        send_query(32'hFFFF_FFFF);
        send_insert('0);
        send_insert(KEY_MAX);
        send_insert('0);                // duplicate key shares its whole path
        // all-ones in every field of an insert
        w.cmd       = bto_pkg::CMD_INSERT;
        w.key_value = KEY_MAX;
        w.rank      = 32'hFFFF_FFFF;
        send_word(w);
        send_insert(30'h2000_0000);     // only the top bit set
        send_insert(30'h0000_0001);     // only the bottom bit set
        send_query(32'd1);              // smallest
        send_query(32'd2);              // second copy of zero
        send_query(32'd3);
        send_query(32'd6);              // total: largest key
        send_query(32'd7);              // one past total
        send_query(32'd0);
        send_query(32'hFFFF_FFFF);
        // all-ones in every field of a query
        w.cmd       = bto_pkg::CMD_QUERY;
        w.key_value = KEY_MAX;
        w.rank      = 32'hFFFF_FFFF;
        send_word(w);
        w.rank = 32'd5;
        send_word(w);
        drain();
    endtask

    // receiver holds off while the sender keeps pushing with no gaps
    task automatic test_backpressure_fill();
        gaps_on    = 1'b0;
        burst_left = 0;
        hold_asked++;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 2 == 0)
                send_insert(KEY_W'($urandom()));
            else
                send_query($urandom_range(1, stored_total + 1));
        end
        gaps_on = 1'b1;
        drain();
    endtask

    // mostly well-formed traffic: inserts with reused and extreme keys, ranks in range
    task automatic test_random_mix(input int n_items);
        logic [KEY_W-1:0] reuse_keys [16];
        logic [KEY_W-1:0] key;
        logic [RANK_W-1:0] k;
        int pick;
        foreach (reuse_keys[i])
            reuse_keys[i] = KEY_W'($urandom());
        for (int i = 0; i < n_items; i++)
        begin
            // stretches with and without sender gaps
            if (i % 200 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 55)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    key = KEY_W'($urandom());
                else if (pick < 70)
                    key = reuse_keys[$urandom_range(0, 15)];
                else if (pick < 85)
                    key = KEY_W'($urandom_range(0, 15));
                else
                    key = KEY_MAX - KEY_W'($urandom_range(0, 15));
                send_insert(key);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70 && stored_total != 0)
                    k = $urandom_range(1, stored_total);
                else if (pick < 80)
                    k = $urandom_range(0, 1) ? stored_total : 32'd1;
                else if (pick < 90)
                    k = $urandom_range(0, 1) ? stored_total + 1 : 32'd0;
                else
                    k = $urandom();
                send_query(k);
            end
        end
        gaps_on = 1'b1;
        drain();
    endtask

    // rank bounds and random ranks on the deep trie left by the mixed traffic
    task automatic test_deep_queries();
        int n;
        send_query(32'd1);
        send_query(stored_total);
        send_query(stored_total + 1);
        n = 0;
        while (n < 20)
        begin
            send_query($urandom_range(1, stored_total));
            n++;
        end
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_backpressure_fill();
        test_random_mix(1840);
        test_deep_queries();

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
